[src/plasma_pattern_pixel_top_assert.svh]
// Assertion macros shared by the plasma pattern RTL.
`ifndef PLASMA_PATTERN_PIXEL_TOP_ASSERT_SVH
`define PLASMA_PATTERN_PIXEL_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define PPP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define PPP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/ppp_pkg.sv]
// Shared constants, types and the sine threshold table for the plasma pattern block.
`timescale 1ns / 1ps
`default_nettype none

package ppp_pkg;

  // Field widths
  localparam int unsigned COORD_W   = 12;
  localparam int unsigned ANGLE_W   = 12;
  localparam int unsigned LEVEL_W   = 8;
  localparam int unsigned NUM_WAVES = 4;
  localparam int unsigned LIN_WAVES = 3;

  // Image bounds; coordinates at or beyond these give level zero
  localparam int unsigned IMAGE_WIDTH  = 4096;
  localparam int unsigned IMAGE_HEIGHT = 4096;

  // Angle scale factors: 2^16 * 4096 / (2*pi*d)
  localparam int unsigned COEF_W = 24;
  localparam logic [COEF_W-1:0] COEF_DIV7 = 24'd6103261;
  localparam logic [COEF_W-1:0] COEF_DIV5 = 24'd8544566;
  localparam logic [COEF_W-1:0] COEF_DIV6 = 24'd7120472;
  localparam logic [COEF_W-1:0] COEF_DIV4 = 24'd10680707;

  localparam int unsigned LIN_SHIFT  = 16;
  localparam int unsigned LIN_PROD_W = LIN_SHIFT + ANGLE_W;
  localparam int unsigned LIN_MUL_W  = COORD_W + 1 + COEF_W;

  // Radius: floor(sqrt((x^2 + y^2) * 2^(2*ROOT_FRAC)))
  localparam int unsigned SQR_W     = 2 * COORD_W;
  localparam int unsigned SQ_W      = SQR_W + 1;
  localparam int unsigned ROOT_FRAC = 4;
  localparam int unsigned ROOT_W    = (SQ_W + 2 * ROOT_FRAC + 1) / 2;
  localparam int unsigned RAD_W     = 2 * ROOT_W;
  localparam int unsigned REM_W     = ROOT_W + 2;

  localparam int unsigned RAD_SHIFT  = 20;
  localparam int unsigned RAD_PROD_W = RAD_SHIFT + ANGLE_W;
  localparam int unsigned RAD_MUL_W  = ROOT_W + COEF_W;

  // Sine lookup
  localparam int unsigned MAG_W = 7;
  localparam int unsigned IDX_W = ANGLE_W - 1;
  localparam int unsigned THR_N = 1 << MAG_W;
  localparam logic [MAG_W-1:0]   MAG_MAX  = '1;
  localparam logic [IDX_W-1:0]   QUARTER  = IDX_W'(1 << (ANGLE_W - 2));
  localparam logic [LEVEL_W-1:0] WAVE_MID = LEVEL_W'(THR_N - 1);
  localparam int unsigned SUM_W = LEVEL_W + $clog2(NUM_WAVES);

  typedef struct packed {
    logic                                oob;
    logic [LIN_WAVES-1:0][ANGLE_W-1:0]   angle;
  } side_t;

  typedef struct packed {
    logic                                oob;
    logic [NUM_WAVES-1:0][ANGLE_W-1:0]   angle;
  } wave_in_t;

  // Entry m: first quarter-wave index whose magnitude reaches m
  typedef logic [THR_N-1:0][IDX_W-1:0] thr_tab_t;

  localparam logic [63:0] PI_Q40  = 64'h3243F6A8885;
  localparam logic [63:0] ONE_Q31 = 64'h80000000;

  // round(127 * sin(a * 2*pi/4096)) over the first quadrant, Q31 series
  function automatic logic [MAG_W-1:0] quarter_sine(input logic [IDX_W-1:0] a);
    logic [63:0] theta;
    logic [63:0] term;
    logic [63:0] s;
    logic [63:0] prod;
    longint      acc;
    logic [3:0]  n;
    theta = (64'(a) * PI_Q40) >> 20;
    term  = theta;
    acc   = longint'(theta);
    for (n = 4'd1; n <= 4'd8; n++) begin
      term = (term * theta) >> 31;
      term = (term * theta) >> 31;
      case (n)
        4'd1:    term = term / 64'd6;
        4'd2:    term = term / 64'd20;
        4'd3:    term = term / 64'd42;
        4'd4:    term = term / 64'd72;
        4'd5:    term = term / 64'd110;
        4'd6:    term = term / 64'd156;
        4'd7:    term = term / 64'd210;
        default: term = term / 64'd272;
      endcase
      if (n[0]) acc = acc - longint'(term);
      else      acc = acc + longint'(term);
    end
    if (acc < 0) acc = 0;
    s = 64'(acc);
    if (s > ONE_Q31) s = ONE_Q31;
    prod = (s * 64'd127 + (ONE_Q31 >> 1)) >> 31;
    return prod[MAG_W-1:0];
  endfunction

  // Magnitude is monotonic over the quadrant, so store its step points
  function automatic thr_tab_t build_sine_thr();
    thr_tab_t         tab;
    int unsigned      a;
    int unsigned      m;
    logic [MAG_W-1:0] mag;
    tab = '0;
    m   = 1;
    for (a = 0; a <= int'(QUARTER); a++) begin
      mag = quarter_sine(IDX_W'(a));
      while (m <= int'(mag)) begin
        tab[MAG_W'(m)] = IDX_W'(a);
        m++;
      end
    end
    return tab;
  endfunction

  localparam thr_tab_t SINE_THR = build_sine_thr();

endpackage

`default_nettype wire

[src/ppp_front.sv]
// Front stages: coordinate products, linear angles and the sum of squares.
`timescale 1ns / 1ps
`default_nettype none

module ppp_front #(
  parameter int unsigned IMAGE_WIDTH  = ppp_pkg::IMAGE_WIDTH,
  parameter int unsigned IMAGE_HEIGHT = ppp_pkg::IMAGE_HEIGHT
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           in_vld,
  input  logic [ppp_pkg::COORD_W-1:0]    in_x,
  input  logic [ppp_pkg::COORD_W-1:0]    in_y,
  input  logic [ppp_pkg::ANGLE_W-1:0]    phase,
  output logic                           out_vld,
  output ppp_pkg::side_t                 out_side,
  output logic [ppp_pkg::SQ_W-1:0]       out_sumsq
);
  import ppp_pkg::*;

  localparam logic [LIN_PROD_W-1:0] LIN_HALF = LIN_PROD_W'(1) << (LIN_SHIFT - 1);

  // Stage A: multiplies
  logic                  vld_a_r;
  logic                  oob_a_r;
  logic [LIN_PROD_W-1:0] p7_a_r;
  logic [LIN_PROD_W-1:0] p5_a_r;
  logic [LIN_PROD_W-1:0] p6_a_r;
  logic [SQR_W-1:0]      xx_a_r;
  logic [SQR_W-1:0]      yy_a_r;

  logic                  oob_nxt;
  logic [LIN_PROD_W-1:0] p7_nxt;
  logic [LIN_PROD_W-1:0] p5_nxt;
  logic [LIN_PROD_W-1:0] p6_nxt;
  logic [SQR_W-1:0]      xx_nxt;
  logic [SQR_W-1:0]      yy_nxt;

  // Stage B: angles and sum of squares
  logic             vld_b_r;
  side_t            side_b_r;
  logic [SQ_W-1:0]  sumsq_b_r;

  side_t            side_nxt;
  logic [SQ_W-1:0]  sumsq_nxt;
  logic [LIN_PROD_W-1:0] r7, r5, r6;

  always_comb begin
    oob_nxt = ((COORD_W + 1)'(in_x) >= (COORD_W + 1)'(IMAGE_WIDTH)) ||
              ((COORD_W + 1)'(in_y) >= (COORD_W + 1)'(IMAGE_HEIGHT));
    p7_nxt  = LIN_PROD_W'(LIN_MUL_W'(in_x) * LIN_MUL_W'(COEF_DIV7));
    p5_nxt  = LIN_PROD_W'(LIN_MUL_W'(in_y) * LIN_MUL_W'(COEF_DIV5));
    p6_nxt  = LIN_PROD_W'(LIN_MUL_W'(LIN_MUL_W'(in_x) + LIN_MUL_W'(in_y)) *
                          LIN_MUL_W'(COEF_DIV6));
    xx_nxt  = SQR_W'(in_x) * SQR_W'(in_x);
    yy_nxt  = SQR_W'(in_y) * SQR_W'(in_y);
  end

  always_comb begin
    // round to the nearest angle unit, keep one turn
    r7 = p7_a_r + LIN_HALF;
    r5 = p5_a_r + LIN_HALF;
    r6 = p6_a_r + LIN_HALF;
    side_nxt.oob      = oob_a_r;
    side_nxt.angle[0] = r7[LIN_SHIFT +: ANGLE_W] + phase;
    side_nxt.angle[1] = r5[LIN_SHIFT +: ANGLE_W] - phase;
    side_nxt.angle[2] = r6[LIN_SHIFT +: ANGLE_W] - phase;
    sumsq_nxt = SQ_W'(xx_a_r) + SQ_W'(yy_a_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
    end else if (en) begin
      vld_a_r <= in_vld;
      vld_b_r <= vld_a_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      oob_a_r   <= oob_nxt;
      p7_a_r    <= p7_nxt;
      p5_a_r    <= p5_nxt;
      p6_a_r    <= p6_nxt;
      xx_a_r    <= xx_nxt;
      yy_a_r    <= yy_nxt;
      side_b_r  <= side_nxt;
      sumsq_b_r <= sumsq_nxt;
    end
  end

  assign out_vld   = vld_b_r;
  assign out_side  = side_b_r;
  assign out_sumsq = sumsq_b_r;

endmodule

`default_nettype wire

[src/ppp_root.sv]
// Pipelined digit-by-digit square root, one result bit per stage.
`timescale 1ns / 1ps
`default_nettype none
`include "plasma_pattern_pixel_top_assert.svh"

module ppp_root (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_vld,
  input  logic [ppp_pkg::SQ_W-1:0]    in_sumsq,
  input  ppp_pkg::side_t              in_side,
  output logic                        out_vld,
  output logic [ppp_pkg::ROOT_W-1:0]  out_root,
  output ppp_pkg::side_t              out_side
);
  import ppp_pkg::*;

  localparam int unsigned CUR_W = REM_W + 2;

  logic              vld_r  [ROOT_W];
  side_t             side_r [ROOT_W];
  logic [REM_W-1:0]  rem_r  [ROOT_W];
  logic [ROOT_W-1:0] root_r [ROOT_W];
  logic [RAD_W-1:0]  rad_r  [ROOT_W];

  logic [REM_W-1:0]  rem_in   [ROOT_W];
  logic [ROOT_W-1:0] root_in  [ROOT_W];
  logic [RAD_W-1:0]  rad_in   [ROOT_W];
  logic [CUR_W-1:0]  cur      [ROOT_W];
  logic [CUR_W-1:0]  trial    [ROOT_W];
  logic [CUR_W-1:0]  diff     [ROOT_W];
  logic              ge       [ROOT_W];
  logic [REM_W-1:0]  rem_nxt  [ROOT_W];
  logic [ROOT_W-1:0] root_nxt [ROOT_W];
  logic [RAD_W-1:0]  rad_nxt  [ROOT_W];

  always_comb begin
    for (int i = 0; i < int'(ROOT_W); i++) begin
      if (i == 0) begin
        rem_in[i]  = '0;
        root_in[i] = '0;
        rad_in[i]  = RAD_W'({in_sumsq, {(2 * ROOT_FRAC){1'b0}}});
      end else begin
        rem_in[i]  = rem_r[i-1];
        root_in[i] = root_r[i-1];
        rad_in[i]  = rad_r[i-1];
      end
      // bring down the next pair of radicand bits and try a one digit
      cur[i]      = {rem_in[i], rad_in[i][RAD_W-1 -: 2]};
      trial[i]    = CUR_W'({root_in[i], 2'b01});
      diff[i]     = cur[i] - trial[i];
      ge[i]       = cur[i] >= trial[i];
      rem_nxt[i]  = ge[i] ? diff[i][REM_W-1:0] : cur[i][REM_W-1:0];
      root_nxt[i] = {root_in[i][ROOT_W-2:0], ge[i]};
      rad_nxt[i]  = rad_in[i] << 2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < int'(ROOT_W); i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_vld;
      for (int i = 1; i < int'(ROOT_W); i++) vld_r[i] <= vld_r[i-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= in_side;
      for (int i = 1; i < int'(ROOT_W); i++) side_r[i] <= side_r[i-1];
      for (int i = 0; i < int'(ROOT_W); i++) begin
        rem_r[i]  <= rem_nxt[i];
        root_r[i] <= root_nxt[i];
        rad_r[i]  <= rad_nxt[i];
      end
    end
  end

  assign out_vld  = vld_r[ROOT_W-1];
  assign out_root = root_r[ROOT_W-1];
  assign out_side = side_r[ROOT_W-1];

  // A floor root leaves a remainder no larger than twice the root
  `PPP_ASSERT_NOW(a_root_rem_bound, vld_r[ROOT_W-1],
    (rem_r[ROOT_W-1] <= {root_r[ROOT_W-1], 1'b0}), "root remainder out of bound")

endmodule

`default_nettype wire

[src/ppp_radial.sv]
// Radial angle: scale the radius and subtract the frame phase.
`timescale 1ns / 1ps
`default_nettype none

module ppp_radial (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_vld,
  input  logic [ppp_pkg::ROOT_W-1:0]  in_root,
  input  ppp_pkg::side_t              in_side,
  input  logic [ppp_pkg::ANGLE_W-1:0] phase,
  output logic                        out_vld,
  output ppp_pkg::wave_in_t           out_wave
);
  import ppp_pkg::*;

  localparam logic [RAD_PROD_W-1:0] RAD_HALF = RAD_PROD_W'(1) << (RAD_SHIFT - 1);

  logic                  vld_p_r;
  side_t                 side_p_r;
  logic [RAD_PROD_W-1:0] prod_p_r;
  logic [RAD_PROD_W-1:0] prod_nxt;

  logic                  vld_q_r;
  wave_in_t              wave_q_r;
  wave_in_t              wave_nxt;
  logic [RAD_PROD_W-1:0] rounded;

  always_comb begin
    prod_nxt = RAD_PROD_W'(RAD_MUL_W'(in_root) * RAD_MUL_W'(COEF_DIV4));
  end

  always_comb begin
    rounded            = prod_p_r + RAD_HALF;
    wave_nxt.oob       = side_p_r.oob;
    wave_nxt.angle     = {rounded[RAD_SHIFT +: ANGLE_W] - phase, side_p_r.angle};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_p_r <= 1'b0;
      vld_q_r <= 1'b0;
    end else if (en) begin
      vld_p_r <= in_vld;
      vld_q_r <= vld_p_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_p_r <= in_side;
      prod_p_r <= prod_nxt;
      wave_q_r <= wave_nxt;
    end
  end

  assign out_vld  = vld_q_r;
  assign out_wave = wave_q_r;

endmodule

`default_nettype wire

[src/ppp_wave.sv]
// Four sine lanes: quadrant fold, pipelined threshold search, term output.
`timescale 1ns / 1ps
`default_nettype none
`include "plasma_pattern_pixel_top_assert.svh"

module ppp_wave (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  logic                                            en,
  input  logic                                            in_vld,
  input  ppp_pkg::wave_in_t                               in_wave,
  output logic                                            out_vld,
  output logic                                            out_oob,
  output logic [ppp_pkg::NUM_WAVES-1:0][ppp_pkg::LEVEL_W-1:0] out_term
);
  import ppp_pkg::*;

  // fold, MAG_W search steps, term
  localparam int unsigned STAGES = MAG_W + 2;

  logic vld_r [STAGES];
  logic oob_r [STAGES];

  logic [IDX_W-1:0]   idx_r  [NUM_WAVES][MAG_W+1];
  logic [MAG_W-1:0]   mag_r  [NUM_WAVES][MAG_W+1];
  logic               neg_r  [NUM_WAVES][MAG_W+1];
  logic [LEVEL_W-1:0] term_r [NUM_WAVES];

  logic [IDX_W-1:0]   idx_nxt  [NUM_WAVES];
  logic [MAG_W-1:0]   cand     [NUM_WAVES][MAG_W+1];
  logic [MAG_W-1:0]   mag_nxt  [NUM_WAVES][MAG_W+1];
  logic [LEVEL_W-1:0] term_nxt [NUM_WAVES];
  logic               ends_bad;

  always_comb begin
    for (int j = 0; j < int'(NUM_WAVES); j++) begin
      // odd quadrants run the quarter wave backward
      if (in_wave.angle[j][ANGLE_W-2])
        idx_nxt[j] = QUARTER - IDX_W'(in_wave.angle[j][ANGLE_W-3:0]);
      else
        idx_nxt[j] = IDX_W'(in_wave.angle[j][ANGLE_W-3:0]);
      cand[j][0]    = '0;
      mag_nxt[j][0] = '0;
      // step s settles magnitude bit MAG_W-s against the step points
      for (int s = 1; s <= int'(MAG_W); s++) begin
        cand[j][s] = mag_r[j][s-1] | (MAG_W'(1) << (MAG_W - s));
        if (SINE_THR[cand[j][s]] <= idx_r[j][s-1])
          mag_nxt[j][s] = cand[j][s];
        else
          mag_nxt[j][s] = mag_r[j][s-1];
      end
      if (neg_r[j][MAG_W])
        term_nxt[j] = WAVE_MID - LEVEL_W'(mag_r[j][MAG_W]);
      else
        term_nxt[j] = WAVE_MID + LEVEL_W'(mag_r[j][MAG_W]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < int'(STAGES); s++) vld_r[s] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_vld;
      for (int s = 1; s < int'(STAGES); s++) vld_r[s] <= vld_r[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      oob_r[0] <= in_wave.oob;
      for (int s = 1; s < int'(STAGES); s++) oob_r[s] <= oob_r[s-1];
      for (int j = 0; j < int'(NUM_WAVES); j++) begin
        idx_r[j][0] <= idx_nxt[j];
        mag_r[j][0] <= mag_nxt[j][0];
        neg_r[j][0] <= in_wave.angle[j][ANGLE_W-1];
        for (int s = 1; s <= int'(MAG_W); s++) begin
          idx_r[j][s] <= idx_r[j][s-1];
          mag_r[j][s] <= mag_nxt[j][s];
          neg_r[j][s] <= neg_r[j][s-1];
        end
        term_r[j] <= term_nxt[j];
      end
    end
  end

  always_comb begin
    for (int j = 0; j < int'(NUM_WAVES); j++) out_term[j] = term_r[j];
  end

  assign out_vld = vld_r[STAGES-1];
  assign out_oob = oob_r[STAGES-1];

  // Zero and the quarter point must land on the ends of the magnitude range
  always_comb begin
    ends_bad = 1'b0;
    for (int j = 0; j < int'(NUM_WAVES); j++) begin
      if ((idx_r[j][MAG_W] == QUARTER) && (mag_r[j][MAG_W] != MAG_MAX)) ends_bad = 1'b1;
      if ((idx_r[j][MAG_W] == '0) && (mag_r[j][MAG_W] != '0)) ends_bad = 1'b1;
    end
  end

  `PPP_ASSERT_NOW(a_wave_ends, vld_r[MAG_W], !ends_bad, "sine search missed an end point")

endmodule

`default_nettype wire

[src/plasma_pattern_pixel_top.sv]
// Plasma pattern pixel generator: top level, phase register and output skid.
//
// Usage:
//   in_*   : one pixel coordinate per item, tdata = {pixel_y, pixel_x}.
//   out_*  : one intensity level per item, in the same order as accepted.
//   cfg_*  : frame phase; write it between frames while the block is empty.
// Throughput: one item per clock while in_tready is high. The work runs
//   through 30 register stages (products, a 17-stage root, radial scaling,
//   a 9-stage sine search), then the output register.
// Stall: the pipeline keeps moving while one result waits on the output;
//   a second finished result parks in a skid register, and in_tready drops
//   only while that skid register is occupied. Nothing is dropped or repeated.
// Reset (rst_n low, synchronous): empties the pipeline and the output, and
//   sets the frame phase to zero.
// Pixels at or beyond the image bounds give a level of zero.
`timescale 1ns / 1ps
`default_nettype none
`include "plasma_pattern_pixel_top_assert.svh"

module plasma_pattern_pixel_top #(
  parameter int unsigned IMAGE_WIDTH  = ppp_pkg::IMAGE_WIDTH,
  parameter int unsigned IMAGE_HEIGHT = ppp_pkg::IMAGE_HEIGHT
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // input items
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [2*ppp_pkg::COORD_W-1:0] in_tdata,   // [11:0] pixel_x, [23:12] pixel_y
  // result items
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [ppp_pkg::LEVEL_W-1:0]  out_tdata,   // [7:0] level
  // frame phase register
  input  logic                         cfg_wr_en,
  input  logic [ppp_pkg::ANGLE_W-1:0]  cfg_wr_data  // [11:0] time_phase
);
  import ppp_pkg::*;

  logic [ANGLE_W-1:0] time_phase_r;

  logic                  en;
  logic                  front_vld;
  side_t                 front_side;
  logic [SQ_W-1:0]       front_sumsq;
  logic                  root_vld;
  logic [ROOT_W-1:0]     root_val;
  side_t                 root_side;
  logic                  rad_vld;
  wave_in_t              rad_wave;
  logic                  wave_vld;
  logic                  wave_oob;
  logic [NUM_WAVES-1:0][LEVEL_W-1:0] wave_term;

  logic [SUM_W-1:0]   sum;
  logic [LEVEL_W-1:0] level;

  logic               out_vld_r;
  logic [LEVEL_W-1:0] out_data_r;
  logic               skid_vld_r;
  logic [LEVEL_W-1:0] skid_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_phase_r <= '0;
    end else if (cfg_wr_en) begin
      time_phase_r <= cfg_wr_data;
    end
  end

  // hold the whole pipeline only while the skid register is occupied
  assign en        = !skid_vld_r;
  assign in_tready = en;

  ppp_front #(
    .IMAGE_WIDTH  (IMAGE_WIDTH),
    .IMAGE_HEIGHT (IMAGE_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_vld    (in_tvalid && in_tready),
    .in_x      (in_tdata[COORD_W-1:0]),
    .in_y      (in_tdata[2*COORD_W-1:COORD_W]),
    .phase     (time_phase_r),
    .out_vld   (front_vld),
    .out_side  (front_side),
    .out_sumsq (front_sumsq)
  );

  ppp_root u_root (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (front_vld),
    .in_sumsq (front_sumsq),
    .in_side  (front_side),
    .out_vld  (root_vld),
    .out_root (root_val),
    .out_side (root_side)
  );

  ppp_radial u_radial (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (root_vld),
    .in_root  (root_val),
    .in_side  (root_side),
    .phase    (time_phase_r),
    .out_vld  (rad_vld),
    .out_wave (rad_wave)
  );

  ppp_wave u_wave (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (rad_vld),
    .in_wave  (rad_wave),
    .out_vld  (wave_vld),
    .out_oob  (wave_oob),
    .out_term (wave_term)
  );

  always_comb begin
    sum = '0;
    for (int j = 0; j < int'(NUM_WAVES); j++) sum = sum + SUM_W'(wave_term[j]);
    level = wave_oob ? '0 : sum[SUM_W-1 -: LEVEL_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (skid_vld_r) begin
      if (out_tready) skid_vld_r <= 1'b0;
    end else if (wave_vld) begin
      // park the new item when the output is still held
      if (out_vld_r && !out_tready) skid_vld_r <= 1'b1;
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_vld_r) begin
      if (out_tready) out_data_r <= skid_data_r;
    end else if (wave_vld) begin
      if (out_vld_r && !out_tready) skid_data_r <= level;
      else                          out_data_r  <= level;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_data_r;

  `PPP_ASSERT_NOW(a_skid_behind_out, skid_vld_r, out_vld_r,
    "skid holds an item while the output register is empty")
  `PPP_ASSERT_NOW(a_skid_fill_cause, $rose(skid_vld_r), $past(out_vld_r && !out_tready),
    "skid filled without a held output")
  `PPP_ASSERT_NEXT(a_skid_drains, skid_vld_r && out_tready, !skid_vld_r,
    "skid did not drain on a taken output")

endmodule

`default_nettype wire
